// ----- rtl/core/hvt_pkg.sv -----
// Shared types and constants for the homogeneous vertex transform.
// No dependencies; used by every module of the block.
package hvt_pkg;

    localparam int FIELD_W   = 32;
    localparam int REG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;

    localparam logic FUNC_DIVIDE = 1'b1;

    typedef struct packed {
        logic func;
        logic sat;
    } t_flags;

endpackage

// ----- rtl/core/hvt_mac.sv -----
// Matrix by vector product: products, pair sums, then round and clamp.
// Depends on hvt_pkg.
module hvt_mac #(
    parameter int CW = 32,
    parameter int F  = 16
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_en,
    input  logic                                                  i_vld,
    input  logic                                                  i_func,
    input  logic [3:0][hvt_pkg::FIELD_W-1:0]                      i_coord,
    input  logic [hvt_pkg::NUM_REGS-1:0][hvt_pkg::REG_W-1:0]      i_mtx,
    output logic                                                  o_vld,
    output logic [3:0][CW-1:0]                                    o_t,
    output hvt_pkg::t_flags                                       o_flags
);
    import hvt_pkg::*;

    localparam int PW = 2 * CW;
    localparam int SW = 2 * CW + 2;
    localparam int RW = SW - F;
    localparam logic signed [SW-1:0] RND = SW'(64'sd1 <<< (F - 1));
    localparam logic signed [RW-1:0] HI  = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] LO  = RW'(-(64'sd1 <<< (CW - 1)));

    logic signed [CW-1:0] w_m [4][4];
    logic signed [CW-1:0] w_v [4];
    logic signed [PW-1:0] r_prod [4][4];
    logic signed [SW-1:0] r_pair [4][2];
    logic [3:0][CW-1:0]   r_t;
    logic [3:0]           w_sat;
    logic [3:0][CW-1:0]   w_t;
    logic                 r_vld1, r_vld2, r_vld3;
    logic                 r_func1, r_func2;
    t_flags               r_flags;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_m[r][c] = $signed(i_mtx[2 * r + c / 2][32 * (c % 2) +: CW]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            w_v[c] = $signed(i_coord[c][CW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_prod[r][c] <= w_m[r][c] * w_v[c];
                end
                r_pair[r][0] <= SW'(r_prod[r][0]) + SW'(r_prod[r][1]) + RND;
                r_pair[r][1] <= SW'(r_prod[r][2]) + SW'(r_prod[r][3]);
            end
            r_t     <= w_t;
            r_func1 <= i_func;
            r_func2 <= r_func1;
            r_flags <= '{func: r_func2, sat: |w_sat};
        end
    end

    always_comb begin
        logic signed [SW-1:0] sum;
        logic signed [RW-1:0] sh;
        for (int r = 0; r < 4; r++) begin
            sum = r_pair[r][0] + r_pair[r][1];
            sh  = RW'(sum >>> F);
            w_sat[r] = 1'b0;
            w_t[r]   = sh[CW-1:0];
            if (sh > HI) begin
                w_sat[r] = 1'b1;
                w_t[r]   = HI[CW-1:0];
            end else if (sh < LO) begin
                w_sat[r] = 1'b1;
                w_t[r]   = LO[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    assign o_vld   = r_vld3;
    assign o_t     = r_t;
    assign o_flags = r_flags;

endmodule

// ----- rtl/core/hvt_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
// Depends on hvt_pkg only through the common import convention.
module hvt_div #(
    parameter int CW = 32,
    parameter int F  = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [CW-1:0] i_num,
    input  logic [CW-1:0] i_den,
    output logic [CW-1:0] o_quo,
    output logic          o_sat
);
    import hvt_pkg::*;

    localparam int ND = CW + F;
    localparam logic [ND-1:0] QHI = ND'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [ND-1:0] QLO = ND'(64'd1 << (CW - 1));

    logic [ND-1:0] r_dvd [ND+1];
    logic [CW-1:0] r_rem [ND+1];
    logic [ND-1:0] r_quo [ND+1];
    logic [CW-1:0] r_dsr [ND+1];
    logic          r_neg [ND+1];
    logic [CW-1:0] w_an, w_ad, r_out;
    logic          r_sat;

    assign w_an = i_num[CW-1] ? CW'(-i_num) : i_num;
    assign w_ad = i_den[CW-1] ? CW'(-i_den) : i_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd[0] <= {w_an, F'(0)} + ND'(w_ad >> 1);
            r_rem[0] <= '0;
            r_quo[0] <= '0;
            r_dsr[0] <= w_ad;
            r_neg[0] <= i_num[CW-1] ^ i_den[CW-1];
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_step
        logic [CW:0] w_try;
        logic        w_ge;
        assign w_try = {r_rem[k], r_dvd[k][ND-1]};
        assign w_ge  = w_try >= {1'b0, r_dsr[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? CW'(w_try - {1'b0, r_dsr[k]}) : CW'(w_try);
                r_quo[k+1] <= {r_quo[k][ND-2:0], w_ge};
                r_dvd[k+1] <= r_dvd[k] << 1;
                r_dsr[k+1] <= r_dsr[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[ND]) begin
                if (r_quo[ND] > QLO) begin
                    r_out <= QLO[CW-1:0];
                    r_sat <= 1'b1;
                end else begin
                    r_out <= CW'(-r_quo[ND]);
                    r_sat <= 1'b0;
                end
            end else if (r_quo[ND] > QHI) begin
                r_out <= QHI[CW-1:0];
                r_sat <= 1'b1;
            end else begin
                r_out <= r_quo[ND][CW-1:0];
                r_sat <= 1'b0;
            end
        end
    end

    assign o_quo = r_out;
    assign o_sat = r_sat;

endmodule

// ----- rtl/core/homogeneous_vertex_transform.sv -----
// Top level of the homogeneous vertex transform.
// Depends on hvt_pkg, hvt_mac and hvt_div.
//
// Input stream: s_tdata carries x, y, z, w (signed fixed point, 32 bits each,
// x lowest); s_tuser selects plain transform (0) or transform then divide by
// w (1). Output stream: m_tdata carries x, y, z, w of the result, m_tuser
// carries the divide-by-zero flag (bit 0) and the saturation flag (bit 1).
// The 4x4 matrix sits in eight 64-bit registers written through i_cfg_wen,
// i_cfg_addr and i_cfg_wdata; write them only while no beat is in flight.
// A beat can enter every cycle while s_tready is high. Each beat passes through
// the dot-product registers, then the divider pipeline with its input and output
// registers around the quotient steps, and last the output register.
// Every beat takes the same path, divide mode or not.
// The whole pipeline advances together; when m_tready is low and the output
// register is full, s_tready falls and every stage holds its beat.
// Reset empties the pipeline and loads the identity matrix.
module homogeneous_vertex_transform #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [4*hvt_pkg::FIELD_W-1:0]        s_tdata,  // in_x, in_y, in_z, in_w
    input  logic                                 s_tuser,  // func
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [4*hvt_pkg::FIELD_W-1:0]        m_tdata,  // out_x, out_y, out_z, out_w
    output logic [1:0]                           m_tuser,  // divided_by_zero, saturated
    input  logic                                 i_cfg_wen,
    input  logic [hvt_pkg::REG_IDX_W-1:0]        i_cfg_addr,
    input  logic [hvt_pkg::REG_W-1:0]            i_cfg_wdata
);
    import hvt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DL = COORD_WIDTH + FRAC_BITS + 2;
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    logic [NUM_REGS-1:0][REG_W-1:0] r_mtx;
    logic                           w_adv;
    logic                           w_mac_vld;
    logic [3:0][CW-1:0]             w_t;
    t_flags                         w_mac_flags;
    logic [2:0][CW-1:0]             w_quo;
    logic [2:0]                     w_qsat;
    logic                           r_sb_vld [DL];
    t_flags                         r_sb_flags [DL];
    logic [3:0][CW-1:0]             r_sb_t [DL];
    logic                           r_out_vld;
    logic [3:0][FIELD_W-1:0]        r_out_data;
    logic [1:0]                     r_out_user;

    assign w_adv    = !r_out_vld || m_tready;
    assign s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtx[0] <= {32'd0, ONE};
            r_mtx[1] <= '0;
            r_mtx[2] <= {ONE, 32'd0};
            r_mtx[3] <= '0;
            r_mtx[4] <= '0;
            r_mtx[5] <= {32'd0, ONE};
            r_mtx[6] <= '0;
            r_mtx[7] <= {ONE, 32'd0};
        end else if (i_cfg_wen) begin
            r_mtx[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    hvt_mac #(.CW(CW), .F(FRAC_BITS)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (s_tvalid),
        .i_func  (s_tuser),
        .i_coord (s_tdata),
        .i_mtx   (r_mtx),
        .o_vld   (w_mac_vld),
        .o_t     (w_t),
        .o_flags (w_mac_flags)
    );

    for (genvar i = 0; i < 3; i++) begin : g_div
        hvt_div #(.CW(CW), .F(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_num (w_t[i]),
            .i_den (w_t[3]),
            .o_quo (w_quo[i]),
            .o_sat (w_qsat[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL; k++) begin
                r_sb_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_sb_vld[0] <= w_mac_vld;
            for (int k = 1; k < DL; k++) begin
                r_sb_vld[k] <= r_sb_vld[k-1];
            end
            r_out_vld <= r_sb_vld[DL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sb_flags[0] <= w_mac_flags;
            r_sb_t[0]     <= w_t;
            for (int k = 1; k < DL; k++) begin
                r_sb_flags[k] <= r_sb_flags[k-1];
                r_sb_t[k]     <= r_sb_t[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic            dz;
        logic            div;
        logic [3:0][CW-1:0] t;
        dz  = 1'b0;
        div = 1'b0;
        t   = r_sb_t[DL-1];
        if (w_adv) begin
            if (r_sb_flags[DL-1].func == FUNC_DIVIDE) begin
                if (t[3] == '0) begin
                    dz = 1'b1;
                end else begin
                    div = 1'b1;
                end
            end
            for (int i = 0; i < 3; i++) begin
                if (dz) begin
                    r_out_data[i] <= '0;
                end else if (div) begin
                    r_out_data[i] <= FIELD_W'($signed(w_quo[i]));
                end else begin
                    r_out_data[i] <= FIELD_W'($signed(t[i]));
                end
            end
            r_out_data[3] <= FIELD_W'($signed(t[3]));
            r_out_user    <= {r_sb_flags[DL-1].sat | (div & (|w_qsat)), dz};
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_user;

endmodule
